// File: hdl/fnsw_pkg.sv
// Package for the fractional-N synthesizer word generator.
// Holds widths, word constants, register addresses and the divider result struct.
`timescale 1ns / 1ps
`default_nettype none
package fnsw_pkg;
  localparam int unsigned FreqW = 32;
  localparam int unsigned RefW = 27;
  localparam int unsigned FracW = 20;
  localparam int unsigned WordW = 18;
  localparam int unsigned DivPerStage = 4;
  localparam logic [RefW-1:0] RefReset = 27'd20000000;
  localparam logic [13:0] ModeData = 14'h1740;
  localparam logic [13:0] FracEnBit = 14'h0400;
  localparam logic [13:0] Reg5Data = 14'h00A4;
  localparam logic [13:0] RefDivBit = 14'h0004;
  localparam logic [7:0] IntMin = 8'd64;
  localparam logic [7:0] IntMax = 8'd255;
  localparam logic [3:0] AddrMode = 4'd0;
  localparam logic [3:0] AddrFracHi = 4'd4;
  localparam logic [3:0] AddrIntFrac = 4'd3;
  localparam logic [3:0] AddrRef = 4'd5;
  localparam logic [2:0] RegRefClk = 3'd0;
  localparam logic [2:0] RegRefDiv = 3'd4;

  // Result of the divider pipeline handed to the word sequencer.
  typedef struct packed {
    logic [7:0] intdiv;
    logic [FracW-1:0] frac;
    logic ref_div;
  } div_res_t;
endpackage
`default_nettype wire

// File: hdl/fnsw_divpipe.sv
// Restoring divider pipeline: quotient of freq by comparison frequency, then
// the 20-bit fraction of remainder*1048575/comp. Uses fnsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fnsw_divpipe
  import fnsw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [FreqW-1:0] freq_i,
  input  wire logic [RefW-1:0]  comp_i,
  input  wire logic             ref_div_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output div_res_t              out_o
);
  // Stage 0..7: integer quotient (32 bits), stage 8..12: fraction (20 bits).
  localparam int unsigned QSt = FreqW / DivPerStage;
  localparam int unsigned FSt = FracW / DivPerStage;
  localparam int unsigned NSt = QSt + FSt;
  localparam int unsigned RemW = RefW + 1;

  logic [NSt-1:0]     vld_q;
  logic [FreqW-1:0]   num_q  [NSt];
  logic [RemW-1:0]    rem_q  [NSt];
  logic [RefW-1:0]    comp_q [NSt];
  logic [FracW-1:0]   fq_q   [NSt];
  logic [NSt-1:0]     rdiv_q;
  logic [NSt-1:0]     adv;

  assign adv[NSt-1] = !vld_q[NSt-1] || out_ready_i;
  for (genvar s = 0; s < NSt - 1; s++) begin : g_adv
    assign adv[s] = !vld_q[s] || adv[s+1];
  end
  assign in_ready_o = adv[0];

  // Fraction: long division of rem*2^20 by c gives floor(rem*2^20/c); the
  // step down to rem*(2^20-1)/c is applied at the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NSt; s++) begin
        if (adv[s]) vld_q[s] <= (s == 0) ? in_valid_i : vld_q[s-1];
      end
    end
  end

  // Quotient stages shift numerator bits in; fraction stages shift in zeros
  // and collect the fraction bits in fq while the numerator holds the quotient.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NSt; s++) begin
      if (adv[s]) begin
        logic [FreqW-1:0] n;
        logic [RemW-1:0]  r;
        logic [FracW-1:0] f;
        logic [RefW-1:0]  c;
        logic [RemW:0]    t;
        logic             bitin;
        if (s == 0) begin
          n = freq_i; r = '0; c = comp_i; f = '0; rdiv_q[s] <= ref_div_i;
        end else begin
          n = num_q[s-1]; r = rem_q[s-1]; c = comp_q[s-1]; f = fq_q[s-1];
          rdiv_q[s] <= rdiv_q[s-1];
        end
        for (int k = 0; k < DivPerStage; k++) begin
          bitin = (s < QSt) ? n[FreqW-1] : 1'b0;
          t = {r, bitin};
          if (t >= {2'b0, c}) begin
            r = RemW'(t - {2'b0, c});
            if (s < QSt) n = {n[FreqW-2:0], 1'b1};
            else f = {f[FracW-2:0], 1'b1};
          end else begin
            r = RemW'(t);
            if (s < QSt) n = {n[FreqW-2:0], 1'b0};
            else f = {f[FracW-2:0], 1'b0};
          end
        end
        num_q[s] <= n; rem_q[s] <= r; comp_q[s] <= c; fq_q[s] <= f;
      end
    end
  end

  // rem*1048575/c = floor(rem*2^20/c) - ceil-ish correction: write
  // rem*2^20 = F*c + R2; rem*(2^20-1) = F*c + R2 - rem, so subtract one
  // when R2 < rem (remainder of the quotient stage kept in qrem_q).
  logic [RefW-1:0] qrem_q [NSt];
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NSt; s++) begin
      if (adv[s]) begin
        if (s == QSt) qrem_q[s] <= rem_q[s-1][RefW-1:0];
        else if (s > QSt) qrem_q[s] <= qrem_q[s-1];
        else qrem_q[s] <= '0;
      end
    end
  end

  always_comb begin
    logic [FreqW-1:0] q;
    logic [FracW-1:0] fr;
    q = num_q[NSt-1];
    fr = fq_q[NSt-1];
    if ({1'b0, qrem_q[NSt-1]} > rem_q[NSt-1] && fr != '0) fr = fr - 1'b1;
    if (comp_q[NSt-1] == '0) begin
      out_o.intdiv = IntMax;
      out_o.frac = '0;
    end else begin
      if (q < FreqW'(IntMin)) out_o.intdiv = IntMin;
      else if (q > FreqW'(IntMax)) out_o.intdiv = IntMax;
      else out_o.intdiv = q[7:0];
      out_o.frac = fr;
    end
    out_o.ref_div = rdiv_q[NSt-1];
  end
  assign out_valid_o = vld_q[NSt-1];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> vld_q[0]) else $error("input blocked with room");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.intdiv >= IntMin) else $error("divider below range");
endmodule
`default_nettype wire

// File: hdl/fnsw_seq.sv
// Word sequencer: turns one divider result into four programming words.
// Uses fnsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fnsw_seq
  import fnsw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire div_res_t          in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       word_o,
  output logic                   last_o
);
  logic [1:0] idx_q;
  logic       fire;
  logic [13:0] data;
  logic [3:0]  addr;

  assign out_valid_o = in_valid_i;
  assign fire = in_valid_i && out_ready_i;
  assign last_o = (idx_q == 2'd3);
  assign in_ready_o = out_ready_i && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0: begin data = ModeData | FracEnBit; addr = AddrMode; end
      2'd1: begin
        data = (Reg5Data & ~RefDivBit) | (in_i.ref_div ? RefDivBit : 14'd0);
        addr = AddrRef;
      end
      2'd2: begin data = {in_i.frac[5:0], in_i.intdiv}; addr = AddrIntFrac; end
      default: begin data = in_i.frac[19:6]; addr = AddrFracHi; end
    endcase
  end
  assign word_o = {data, addr};

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_o |=> idx_q == 2'd0) else $error("sequence out of step");
endmodule
`default_nettype wire

// File: hdl/frac_n_synth_word_generator.sv
// Top level of the fractional-N synthesizer word generator: APB registers,
// divider pipeline, word sequencer, output register. Uses fnsw_pkg, fnsw_divpipe, fnsw_seq.
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata[31:0] freq_hz
//  m_axis  | out | tvalid/tready    | tdata[17:0] spi_word, tlast last_word
//  apb     | in  | psel/penable     | paddr[2:0], pwdata 32 bits
// Each item yields four words, one a cycle while m_axis does not stall; the divider
// can accept new items while earlier ones are in its stages or in the sequencer.
// Words pass the 13 divider stages, the combinational sequencer and the output register.
// Reset clears valid bits and registers to 20 MHz reference, no halving.
// A stall on m_axis holds the output register; valid stages behind a held stage hold.
`timescale 1ns / 1ps
`default_nettype none
module frac_n_synth_word_generator
  import fnsw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // freq_hz
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // spi_word, zero fill
  output logic             m_axis_tlast,   // last_word
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [RefW-1:0] ref_q;
  logic            rdiv_q;
  logic            dv, dr, sv, sr, wr_o, last_s, ovld_q, olast_q;
  logic [WordW-1:0] word_s, oword_q;
  div_res_t        dres;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= RefReset;
      rdiv_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegRefClk) ref_q <= pwdata[RefW-1:0];
      else if (paddr == RegRefDiv) rdiv_q <= pwdata[0];
    end
  end
  always_comb begin
    case (paddr)
      RegRefClk: prdata = {5'd0, ref_q};
      RegRefDiv: prdata = {31'd0, rdiv_q};
      default: prdata = '0;
    endcase
  end

  fnsw_divpipe u_div (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .freq_i(s_axis_tdata), .comp_i(rdiv_q ? {1'b0, ref_q[RefW-1:1]} : ref_q),
    .ref_div_i(rdiv_q),
    .out_valid_o(dv), .out_ready_i(dr), .out_o(dres)
  );

  fnsw_seq u_seq (
    .clk_i, .rst_ni,
    .in_valid_i(dv), .in_ready_o(dr), .in_i(dres),
    .out_valid_o(sv), .out_ready_i(sr), .word_o(word_s), .last_o(last_s)
  );

  assign sr = !ovld_q || m_axis_tready;
  assign wr_o = sv && sr;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (sr) ovld_q <= sv;
  end
  always_ff @(posedge clk_i) begin
    if (wr_o) begin
      oword_q <= word_s;
      olast_q <= last_s;
    end
  end
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {6'd0, oword_q};
  assign m_axis_tlast = olast_q;
endmodule
`default_nettype wire

// File: sim/frac_n_synth_word_generator_tb.sv
// Testbench for frac_n_synth_word_generator: drives frequency requests on the
// input stream, predicts the four programming words of each, checks the output.
// Depends on fnsw_pkg and the RTL top level only.
`timescale 1ns / 1ps
module frac_n_synth_word_generator_tb;
  import fnsw_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] spi_word;
    logic             last_word;
  } synth_word_t;

  typedef struct {
    logic [31:0]      freq;
    logic             has_word;  // expected word typed in for this row
    logic [WordW-1:0] word3;     // expected int/frac word
  } freq_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [RefW-1:0] ref_clk_q = RefReset;
  logic            ref_div_q = 1'b0;
  synth_word_t     word_q[$];
  int              errors = 0;
  bit              calm = 1'b0;   // no idling when set

  always #6 clk_i = ~clk_i;

  frac_n_synth_word_generator u_top (.*);

  function automatic logic [WordW-1:0] mk_word(logic [13:0] data, logic [3:0] addr);
    return {data, addr};
  endfunction

  // Predict the four words for one frequency request.
  task automatic predict_words(input logic [31:0] freq);
    logic [31:0] comp, q, r;
    logic [7:0]  idiv;
    logic [FracW-1:0] frac;
    logic [13:0] d5;
    comp = ref_div_q ? 32'(ref_clk_q >> 1) : 32'(ref_clk_q);
    if (comp == 0) begin
      idiv = IntMax;
      frac = '0;
    end else begin
      q = freq / comp;
      r = freq % comp;
      idiv = (q < 64) ? IntMin : (q > 255) ? IntMax : q[7:0];
      frac = FracW'((64'(r) * 64'd1048575) / 64'(comp));
    end
    d5 = (Reg5Data & ~RefDivBit) | (ref_div_q ? RefDivBit : 14'h0);
    word_q.push_back('{mk_word(ModeData | FracEnBit, AddrMode), 1'b0});
    word_q.push_back('{mk_word(d5, AddrRef), 1'b0});
    word_q.push_back('{mk_word({frac[5:0], idiv}, AddrIntFrac), 1'b0});
    word_q.push_back('{mk_word(frac[19:6], AddrFracHi), 1'b1});
  endtask

  task automatic send_freq(input logic [31:0] freq);
    if (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 33) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= freq;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_words(freq);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == RegRefClk) ref_clk_q = data[RefW-1:0];
    else if (addr == RegRefDiv) ref_div_q = data[0];
    @(posedge clk_i);
  endtask

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Output side: random stall and check against the oldest expectation.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (word_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        synth_word_t exp_w;
        exp_w = word_q.pop_front();
        if (m_axis_tdata[WordW-1:0] !== exp_w.spi_word || m_axis_tdata[23:WordW] !== '0) begin
          $display("%0t: spi_word expected %h actual %h", $time, exp_w.spi_word, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== exp_w.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time, exp_w.last_word,
                   m_axis_tlast);
          errors++;
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 33);
  end

  initial begin
    freq_row_t rows[$];
    logic [31:0] fr;
    int          k;
    // After reset, comp = 20 MHz: low clamp, top of the input range, exact, mid remainder.
    rows = '{
      '{32'd0, 1'b1, mk_word({6'd0, 8'd64}, AddrIntFrac)},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'd1_280_000_000, 1'b1, mk_word({6'd0, 8'd64}, AddrIntFrac)},
      '{32'd805_032_704, 1'b0, '0},
      '{32'd2_400_000_000, 1'b1, mk_word({6'd0, 8'd120}, AddrIntFrac)},
      '{32'd2_410_000_000, 1'b0, '0},
      '{32'd1_000_000_000, 1'b0, '0},
      '{32'd19_999_999, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_freq(rows[i].freq);
      if (rows[i].has_word && word_q[word_q.size()-2].spi_word !== rows[i].word3) begin
        $display("%0t: typed word expected %h predicted %h", $time, rows[i].word3,
                 word_q[word_q.size()-2].spi_word);
        errors++;
      end
    end
    drain_words();
    // Register extremes, halving, and a zero comparison frequency.
    apb_write(RegRefClk, 32'd100_000_000);
    apb_write(RegRefDiv, 32'd1);
    send_freq(32'd0); send_freq(32'hFFFF_FFFF); send_freq(32'd3_200_000_000);
    drain_words();
    apb_write(RegRefClk, 32'd1_000_000);
    apb_write(RegRefDiv, 32'd0);
    send_freq(32'd255_999_999); send_freq(32'hFFFF_FFFF); send_freq(32'd63_999_999);
    drain_words();
    apb_write(RegRefClk, 32'd1);
    apb_write(RegRefDiv, 32'd1);
    send_freq(32'd1234); send_freq(32'hFFFF_FFFF);
    drain_words();
    // Random phases with random register settings.
    for (int ph = 0; ph < 5; ph++) begin
      apb_write(RegRefClk, (ph == 4) ? 32'h7FF_FFFF : $urandom_range(100_000_000, 1_000_000));
      apb_write(RegRefDiv, $urandom_range(1));
      calm = (ph == 2);
      for (k = 0; k < 40; k++) begin
        case ($urandom_range(3))
          0: fr = $urandom();
          1: fr = (ref_div_q ? ref_clk_q >> 1 : ref_clk_q) * $urandom_range(255, 64)
                  + $urandom_range(1_000_000);
          default: fr = $urandom_range(32'd2_500_000_000, 32'd1_300_000_000);
        endcase
        send_freq(fr);
      end
      drain_words();
    end
    calm = 1'b0;
    if (errors == 0) $display("frac_n_synth_word_generator_tb passed");
    else $display("frac_n_synth_word_generator_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("frac_n_synth_word_generator_tb failed");
    $finish;
  end
endmodule
